// ----- design/prt_pkg.sv -----
// Shared types, widths and codes for the task table scheduler.
`timescale 1ns / 1ps

package prt_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int HW_W        = $clog2(TABLE_SLOTS + 1);
    localparam int ID_W        = 8;

    typedef logic [2:0] t_cmd;
    typedef logic [2:0] t_status;

    localparam t_cmd CMD_APPEND = 3'd0;
    localparam t_cmd CMD_CREATE = 3'd1;
    localparam t_cmd CMD_EXIT   = 3'd2;
    localparam t_cmd CMD_YIELD  = 3'd3;
    localparam t_cmd CMD_ENQ    = 3'd4;
    localparam t_cmd CMD_QUERY  = 3'd5;

    localparam t_status ST_UNUSED  = 3'd0;
    localparam t_status ST_READY   = 3'd1;
    localparam t_status ST_RUNNING = 3'd2;
    localparam t_status ST_WAITING = 3'd3;
    localparam t_status ST_DEAD    = 3'd4;

    typedef struct packed {
        logic [7:0]  prio;
        logic [31:0] flags;
        logic [7:0]  parent;
        logic [31:0] disp;
    } t_entry;

    typedef struct packed {
        logic              done;
        logic              found;
        logic [SLOT_W-1:0] idx;
    } t_scan_res;

endpackage

// ----- design/prt_ram.sv -----
// Generic single-port-write RAM with a registered read port.
`timescale 1ns / 1ps

module prt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/prt_scan.sv -----
// Circular slot scan unit that tests one slot status per cycle.
`timescale 1ns / 1ps

module prt_scan import prt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SLOT_W-1:0] i_first,
    input  logic [HW_W-1:0]   i_count,
    input  t_status           i_target,
    input  t_status           i_status [TABLE_SLOTS],
    output t_scan_res         o_res
);

    logic              r_busy;
    logic [SLOT_W-1:0] r_idx;
    logic [HW_W-1:0]   r_left;
    t_status           r_target;
    logic              n_busy;
    logic [SLOT_W-1:0] n_idx;
    logic [HW_W-1:0]   n_left;
    t_status           n_target;
    logic              hit;

    assign hit = (i_status[r_idx] == r_target);

    always_comb begin
        n_busy   = r_busy;
        n_idx    = r_idx;
        n_left   = r_left;
        n_target = r_target;
        o_res    = '0;
        if (i_start) begin
            n_busy   = 1'b1;
            n_idx    = i_first;
            n_left   = i_count;
            n_target = i_target;
        end else if (r_busy) begin
            if (hit || (r_left == HW_W'(1))) begin
                o_res.done  = 1'b1;
                o_res.found = hit;
                o_res.idx   = r_idx;
                n_busy      = 1'b0;
            end else begin
                n_left = r_left - HW_W'(1);
                if (r_idx == SLOT_W'(TABLE_SLOTS - 1)) begin
                    n_idx = '0;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_idx    <= n_idx;
        r_left   <= n_left;
        r_target <= n_target;
    end

endmodule

// ----- design/process_table_round_robin.sv -----
// Top level of the task table with its command sequencer and round-robin yield.
// Items are decoded, then the slot entry is read and, where needed, written, then the result is
// shown; a slot out of range, a full table or an undefined command goes straight to the result.
// Create and a yield with high water above 1 first run the scan unit; a failed create skips the RAM.
// One item at a time: the next item is taken in the cycle after the result is taken.
// Synchronous reset clears all statuses, slot valid bits, current task and high water.
`timescale 1ns / 1ps

module process_table_round_robin import prt_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [2:0]      i_cmd,
    input  logic [ID_W-1:0] i_task_id,
    input  logic [7:0]      i_prio_in,
    input  logic [31:0]     i_flag_bits_in,
    input  logic [7:0]      i_parent_in,
    output logic            o_valid,
    input  logic            i_stall,
    output logic            o_ok,
    output logic [ID_W-1:0] o_id_out,
    output logic [2:0]      o_status_out,
    output logic [7:0]      o_prio_out,
    output logic [31:0]     o_flag_bits_out,
    output logic [7:0]      o_parent_out,
    output logic [31:0]     o_dispatch_count_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_RDW  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]        r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [ID_W-1:0]   r_tid, n_tid;
    logic [7:0]        r_prio, n_prio;
    logic [31:0]       r_flg, n_flg;
    logic [7:0]        r_par, n_par;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_bump, n_bump;
    logic [SLOT_W-1:0] r_cur, n_cur;
    logic [HW_W-1:0]   r_hw, n_hw;
    t_status           r_status [TABLE_SLOTS];
    t_status           n_status [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_valid, n_valid;
    logic              r_ok, n_ok;
    logic [ID_W-1:0]   r_out_id, n_out_id;
    t_status           r_out_status, n_out_status;
    t_entry            r_out_entry, n_out_entry;

    logic              scan_start;
    logic [SLOT_W-1:0] scan_first;
    logic [HW_W-1:0]   scan_count;
    t_status           scan_target;
    t_scan_res         scan_res;

    logic              ram_we;
    logic [$bits(t_entry)-1:0] ram_rdata;
    t_entry            rd_entry, wr_entry;
    logic              tid_ok;
    logic [SLOT_W-1:0] tid_slot;
    logic [SLOT_W-1:0] cur_next;

    assign tid_ok   = ({1'b0, r_tid} < (ID_W + 1)'(TABLE_SLOTS));
    assign tid_slot = r_tid[SLOT_W-1:0];
    assign cur_next = (r_cur == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : r_cur + SLOT_W'(1);
    assign rd_entry = r_valid[r_slot] ? t_entry'(ram_rdata) : '0;

    prt_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (scan_start),
        .i_first  (scan_first),
        .i_count  (scan_count),
        .i_target (scan_target),
        .i_status (r_status),
        .o_res    (scan_res)
    );

    prt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (wr_entry),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_tid        = r_tid;
        n_prio       = r_prio;
        n_flg        = r_flg;
        n_par        = r_par;
        n_slot       = r_slot;
        n_bump       = r_bump;
        n_cur        = r_cur;
        n_hw         = r_hw;
        n_status     = r_status;
        n_valid      = r_valid;
        n_ok         = r_ok;
        n_out_id     = r_out_id;
        n_out_status = r_out_status;
        n_out_entry  = r_out_entry;
        scan_start   = 1'b0;
        scan_first   = '0;
        scan_count   = '0;
        scan_target  = ST_UNUSED;
        ram_we       = 1'b0;
        wr_entry     = rd_entry;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd   = i_cmd;
                    n_tid   = i_task_id;
                    n_prio  = i_prio_in;
                    n_flg   = i_flag_bits_in;
                    n_par   = i_parent_in;
                    n_bump  = 1'b0;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_ok         = 1'b0;
                n_out_id     = '0;
                n_out_status = ST_UNUSED;
                n_out_entry  = '0;
                n_state      = S_OUT;
                case (r_cmd)
                    CMD_APPEND: begin
                        if (r_hw < HW_W'(TABLE_SLOTS)) begin
                            n_slot                       = r_hw[SLOT_W-1:0];
                            n_status[r_hw[SLOT_W-1:0]] = ST_READY;
                            n_hw                         = r_hw + HW_W'(1);
                            n_ok                         = 1'b1;
                            n_state                      = S_RD;
                        end
                    end
                    CMD_CREATE: begin
                        scan_start  = 1'b1;
                        scan_first  = '0;
                        scan_count  = HW_W'(TABLE_SLOTS);
                        scan_target = ST_UNUSED;
                        n_state     = S_SCAN;
                    end
                    CMD_EXIT: begin
                        n_status[r_cur] = ST_DEAD;
                        n_slot          = r_cur;
                        n_ok            = 1'b1;
                        n_state         = S_RD;
                    end
                    CMD_YIELD: begin
                        if (r_hw <= HW_W'(1)) begin
                            n_slot  = r_cur;
                            n_state = S_RD;
                        end else begin
                            scan_start  = 1'b1;
                            scan_first  = cur_next;
                            scan_count  = HW_W'(TABLE_SLOTS - 1);
                            scan_target = ST_READY;
                            n_bump      = 1'b1;
                            n_state     = S_SCAN;
                        end
                    end
                    CMD_ENQ: begin
                        n_out_id = r_tid;
                        if (tid_ok) begin
                            n_slot  = tid_slot;
                            n_state = S_RD;
                            if ((r_status[tid_slot] != ST_UNUSED) &&
                                (r_status[tid_slot] != ST_DEAD)) begin
                                n_status[tid_slot] = ST_READY;
                                n_ok               = 1'b1;
                            end
                        end
                    end
                    CMD_QUERY: begin
                        n_out_id = r_tid;
                        if (tid_ok) begin
                            n_slot  = tid_slot;
                            n_ok    = (r_status[tid_slot] != ST_UNUSED);
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_SCAN: begin
                if (scan_res.done) begin
                    if (r_cmd == CMD_CREATE) begin
                        if (scan_res.found) begin
                            n_slot                 = scan_res.idx;
                            n_status[scan_res.idx] = ST_READY;
                            if (HW_W'(scan_res.idx) >= r_hw) begin
                                n_hw = HW_W'(scan_res.idx) + HW_W'(1);
                            end
                            n_ok    = 1'b1;
                            n_state = S_RD;
                        end else begin
                            n_state = S_OUT;
                        end
                    end else begin
                        if (scan_res.found) begin
                            if (r_status[r_cur] != ST_DEAD) begin
                                n_status[r_cur] = ST_READY;
                            end
                            n_status[scan_res.idx] = ST_RUNNING;
                            n_cur                  = scan_res.idx;
                            n_slot                 = scan_res.idx;
                            n_ok                   = 1'b1;
                        end else begin
                            n_slot = r_cur;
                        end
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_RDW;
            end
            S_RDW: begin
                case (r_cmd)
                    CMD_APPEND: begin
                        wr_entry.prio = r_prio;
                        ram_we        = 1'b1;
                    end
                    CMD_CREATE: begin
                        wr_entry.prio   = r_prio;
                        wr_entry.flags  = r_flg;
                        wr_entry.parent = r_par;
                        wr_entry.disp   = '0;
                        ram_we          = 1'b1;
                    end
                    CMD_YIELD: begin
                        if (r_bump) begin
                            wr_entry.disp = rd_entry.disp + 32'd1;
                            ram_we        = 1'b1;
                        end
                    end
                    default: begin
                        ram_we = 1'b0;
                    end
                endcase
                if (ram_we) begin
                    n_valid[r_slot] = 1'b1;
                end
                n_out_id     = ID_W'(r_slot);
                n_out_status = r_status[r_slot];
                n_out_entry  = wr_entry;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= '0;
            r_hw    <= '0;
            r_valid <= '0;
            for (int k = 0; k < TABLE_SLOTS; k++) begin
                r_status[k] <= ST_UNUSED;
            end
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_hw     <= n_hw;
            r_valid  <= n_valid;
            r_status <= n_status;
        end
        r_cmd        <= n_cmd;
        r_tid        <= n_tid;
        r_prio       <= n_prio;
        r_flg        <= n_flg;
        r_par        <= n_par;
        r_slot       <= n_slot;
        r_bump       <= n_bump;
        r_ok         <= n_ok;
        r_out_id     <= n_out_id;
        r_out_status <= n_out_status;
        r_out_entry  <= n_out_entry;
    end

    assign o_stall              = (r_state != S_IDLE);
    assign o_valid              = (r_state == S_OUT);
    assign o_ok                 = r_ok;
    assign o_id_out             = r_out_id;
    assign o_status_out         = r_out_status;
    assign o_prio_out           = r_out_entry.prio;
    assign o_flag_bits_out      = r_out_entry.flags;
    assign o_parent_out         = r_out_entry.parent;
    assign o_dispatch_count_out = r_out_entry.disp;

endmodule

// ----- design/prt_checker.sv -----
// Port-level checker for the task table scheduler and its bind to the top level.
`timescale 1ns / 1ps

module prt_checker import prt_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_stall,
    input logic [2:0]      i_cmd,
    input logic [ID_W-1:0] i_task_id,
    input logic [7:0]      i_prio_in,
    input logic [31:0]     i_flag_bits_in,
    input logic [7:0]      i_parent_in,
    input logic            o_valid,
    input logic            i_stall,
    input logic            o_ok,
    input logic [ID_W-1:0] o_id_out,
    input logic [2:0]      o_status_out,
    input logic [7:0]      o_prio_out,
    input logic [31:0]     o_flag_bits_out,
    input logic [7:0]      o_parent_out,
    input logic [31:0]     o_dispatch_count_out
);

    logic id_in_range;

    assign id_in_range = ({1'b0, o_id_out} < (ID_W + 1)'(TABLE_SLOTS));

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("A stalled result item was withdrawn.");

    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("An item could be taken while a result item waits.");

    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall && !o_valid)
        else $error("A result item appeared in the cycle after an item was taken.");

    a_ok_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ok |-> o_status_out != ST_UNUSED)
        else $error("A successful result reports an unused slot.");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !id_in_range |-> !o_ok && o_status_out == ST_UNUSED &&
            o_prio_out == 8'd0 && o_flag_bits_out == 32'd0 &&
            o_parent_out == 8'd0 && o_dispatch_count_out == 32'd0)
        else $error("A result for a slot out of range carries slot data.");

endmodule

bind process_table_round_robin prt_checker u_prt_checker (.*);
